// ----- design/lfrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared constants and controller/datapath interface types for the
// lowest-free resource scheduler.
// ----------------------------------------------------------------------------
package lfrs_pkg;

	// Number of resources and width of the stored free times.
	localparam int ROOMS     = 16;
	localparam int TIME_BITS = 40;

	// Field widths fixed by the interface.
	localparam int IN_W    = 20;
	localparam int COUNT_W = 20;
	localparam int CFG_W   = 5;
	localparam int ROOM_W  = (ROOMS > 1) ? $clog2(ROOMS) : 1;

	localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
	localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
	localparam logic [CFG_W-1:0]     ROOM_COUNT_RST = CFG_W'(16);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;      // capture the job from the input port
		logic              rd_en;     // read the state memory
		logic              rd_pick;   // read address is the chosen room
		logic [ROOM_W-1:0] rd_idx;    // scan read address
		logic              cmp_scan;  // compare a free time against the start
		logic              cmp_top;   // compare a use count against the best
		logic [ROOM_W-1:0] cmp_idx;   // room index of the data being compared
		logic              calc_fin;  // choose the room and its finish time
		logic              write;     // write back free time and use count
		logic              out_load;  // load the output register
	} lfrs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [ROOM_W-1:0] last_idx;  // highest room index in use
		logic              last_job;  // the job in flight is marked last
		logic              out_busy;  // output register holds a stalled result
	} lfrs_sts_t;

endpackage

// ----- design/lfrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfrs_ctrl
// Sequencer for the scheduler: scans free times, books the chosen room,
// optionally scans use counts, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lfrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lfrs_pkg::lfrs_sts_t sts,
	output lfrs_pkg::lfrs_cmd_t cmd
);
	import lfrs_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_SCANE = 4'd2;
	localparam logic [3:0] ST_FIN   = 4'd3;
	localparam logic [3:0] ST_CRD   = 4'd4;
	localparam logic [3:0] ST_CWR   = 4'd5;
	localparam logic [3:0] ST_TOP   = 4'd6;
	localparam logic [3:0] ST_TOPE  = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]        state_q, state_d;
	logic [ROOM_W-1:0] idx_q, idx_d;
	logic              cv_q;   // read data of a scan is valid this cycle
	logic [ROOM_W-1:0] ri_q;   // room index of that read data
	logic              accept;
	logic              scan_rd;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign scan_rd  = (state_q == ST_SCAN) || (state_q == ST_TOP);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
					idx_d   = '0;
				end
			end
			ST_SCAN: begin
				if (idx_q == sts.last_idx) begin
					state_d = ST_SCANE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_SCANE: state_d = ST_FIN;
			ST_FIN:   state_d = ST_CRD;
			ST_CRD:   state_d = ST_CWR;
			ST_CWR: begin
				idx_d = '0;
				if (sts.last_job) begin
					state_d = ST_TOP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_TOP: begin
				if (idx_q == sts.last_idx) begin
					state_d = ST_TOPE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_TOPE: state_d = ST_DONE;
			ST_DONE: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cv_q    <= 1'b0;
			ri_q    <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cv_q    <= scan_rd;
			ri_q    <= idx_q;
		end
	end

	always_comb begin
		cmd.load     = accept;
		cmd.rd_en    = scan_rd || (state_q == ST_CRD);
		cmd.rd_pick  = (state_q == ST_CRD);
		cmd.rd_idx   = idx_q;
		cmd.cmp_scan = cv_q && ((state_q == ST_SCAN) || (state_q == ST_SCANE));
		cmd.cmp_top  = cv_q && ((state_q == ST_TOP) || (state_q == ST_TOPE));
		cmd.cmp_idx  = ri_q;
		cmd.calc_fin = (state_q == ST_FIN);
		cmd.write    = (state_q == ST_CWR);
		cmd.out_load = (state_q == ST_DONE) && !sts.out_busy;
	end

endmodule

// ----- design/lfrs_dp.sv -----
// ----------------------------------------------------------------------------
// lfrs_dp
// Datapath: room state memory, scan comparators, finish time arithmetic,
// configuration register and the output register.
// ----------------------------------------------------------------------------
module lfrs_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lfrs_pkg::lfrs_cmd_t                cmd,
	output lfrs_pkg::lfrs_sts_t                sts,
	input  logic                               cfg_valid,
	input  logic [lfrs_pkg::CFG_W-1:0]         cfg_data,
	input  logic [lfrs_pkg::IN_W-1:0]          start_time,
	input  logic [lfrs_pkg::IN_W-1:0]          end_time,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lfrs_pkg::ROOM_W-1:0]        room,
	output logic [lfrs_pkg::TIME_BITS-1:0]     finish_time,
	output logic [lfrs_pkg::ROOM_W-1:0]        top_room,
	output logic                               done_res
);
	import lfrs_pkg::*;

	// State memory; entries read as zero until first written.
	logic [TIME_BITS-1:0] free_mem [ROOMS];
	logic [COUNT_W-1:0]   cnt_mem  [ROOMS];
	logic [ROOMS-1:0]     vld_q;

	logic [CFG_W-1:0]     room_count_q;
	logic [IN_W-1:0]      start_q;
	logic [IN_W-1:0]      end_q;
	logic [IN_W-1:0]      dur_q;
	logic                 last_q;

	logic [ROOM_W-1:0]    rd_addr;
	logic [TIME_BITS-1:0] rd_free_q;
	logic [COUNT_W-1:0]   rd_cnt_q;

	logic                 found_q;
	logic [ROOM_W-1:0]    scan_pick_q;
	logic [ROOM_W-1:0]    early_q;
	logic [TIME_BITS-1:0] early_val_q;
	logic [ROOM_W-1:0]    best_q;
	logic [COUNT_W-1:0]   best_cnt_q;
	logic [ROOM_W-1:0]    pick_q;
	logic [TIME_BITS-1:0] finish_q;

	logic [TIME_BITS-1:0] start_ext;
	logic                 is_free;
	logic [TIME_BITS:0]   delay_sum;
	logic                 out_valid_q;

	assign start_ext = TIME_BITS'(start_q);
	assign is_free   = (rd_free_q <= start_ext);
	assign delay_sum = {1'b0, early_val_q} + (TIME_BITS + 1)'(dur_q);
	assign rd_addr   = cmd.rd_pick ? pick_q : cmd.rd_idx;

	// Clamp the configured count to the rooms that exist.
	always_comb begin
		sts.last_job = last_q;
		sts.out_busy = out_valid_q && out_stall;
		if (room_count_q == '0) begin
			sts.last_idx = '0;
		end else if (int'(room_count_q) > ROOMS) begin
			sts.last_idx = ROOM_W'(ROOMS - 1);
		end else begin
			sts.last_idx = ROOM_W'(room_count_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= ROOM_COUNT_RST;
		end else if (cfg_valid) begin
			room_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			free_mem[pick_q] <= finish_q;
			cnt_mem[pick_q]  <= (rd_cnt_q == COUNT_MAX) ? rd_cnt_q : rd_cnt_q + 1'b1;
		end
		if (cmd.rd_en) begin
			rd_free_q <= vld_q[rd_addr] ? free_mem[rd_addr] : '0;
			rd_cnt_q  <= vld_q[rd_addr] ? cnt_mem[rd_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.write) begin
			vld_q[pick_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= start_time;
			end_q   <= end_time;
			dur_q   <= (end_time > start_time) ? end_time - start_time : '0;
			last_q  <= last;
		end
		if (cmd.cmp_scan) begin
			if (cmd.cmp_idx == '0) begin
				found_q     <= is_free;
				scan_pick_q <= '0;
				early_q     <= '0;
				early_val_q <= rd_free_q;
			end else begin
				if (!found_q && is_free) begin
					found_q     <= 1'b1;
					scan_pick_q <= cmd.cmp_idx;
				end
				if (rd_free_q < early_val_q) begin
					early_q     <= cmd.cmp_idx;
					early_val_q <= rd_free_q;
				end
			end
		end
		if (cmd.cmp_top) begin
			if (cmd.cmp_idx == '0 || rd_cnt_q > best_cnt_q) begin
				best_q     <= cmd.cmp_idx;
				best_cnt_q <= rd_cnt_q;
			end
		end
		if (cmd.calc_fin) begin
			if (found_q) begin
				pick_q   <= scan_pick_q;
				finish_q <= TIME_BITS'(end_q);
			end else begin
				pick_q   <= early_q;
				finish_q <= delay_sum[TIME_BITS] ? TIME_MAX : delay_sum[TIME_BITS-1:0];
			end
		end
		if (cmd.out_load) begin
			room        <= pick_q;
			finish_time <= finish_q;
			top_room    <= last_q ? best_q : '0;
			done_res    <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/lowest_free_resource_scheduler.sv -----
// ----------------------------------------------------------------------------
// lowest_free_resource_scheduler
// Books each job on the lowest-numbered free room, or delays it onto the
// room that frees earliest, and reports booking and usage results.
// ----------------------------------------------------------------------------
// Each job runs from acceptance until the block returns to idle, and only
// then is the next job taken. The scan covers room_count rooms (clamped to
// 1..16). The room state memory has one read port: the free times are read
// one room per cycle, then the chosen room's use count is read and written
// back. A job marked last adds a second pass over the use counts to find
// the most used room. The result sits in an output register, so a stalled
// result does not hold off the next job; only the hand-off of the following
// result waits for it. Jobs are expected in ascending start order and are
// handled exactly as presented. Free times saturate at all ones and use
// counts at 2^20 - 1. The room count register may be written at any time
// the block has no job in flight and no result waiting; cfg_ready is always
// high. Room state is cleared only by reset.
// ----------------------------------------------------------------------------
module lowest_free_resource_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	// Room count configuration channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lfrs_pkg::CFG_W-1:0]     cfg_data,
	// Job input channel: a transaction completes when in_valid is high and
	// in_stall is low.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lfrs_pkg::IN_W-1:0]      start_time,
	input  logic [lfrs_pkg::IN_W-1:0]      end_time,
	input  logic                           last,
	// Result output channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lfrs_pkg::ROOM_W-1:0]    room,
	output logic [lfrs_pkg::TIME_BITS-1:0] finish_time,
	output logic [lfrs_pkg::ROOM_W-1:0]    top_room,
	output logic                           done_res
);
	import lfrs_pkg::*;

	lfrs_cmd_t cmd;
	lfrs_sts_t sts;

	// The register is a plain flop, so a configuration transaction always
	// completes in the cycle that cfg_valid is high.
	assign cfg_ready = 1'b1;

	// The controller owns sequencing; it sees the datapath only through the
	// command and status structs.
	lfrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfrs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.start_time  (start_time),
		.end_time    (end_time),
		.last        (last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.room        (room),
		.finish_time (finish_time),
		.top_room    (top_room),
		.done_res    (done_res)
	);

	// An accepted job keeps the input stalled for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a job was accepted");

	// The top room is reported only on the result of the last job.
	a_top_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !done_res) |-> (top_room == '0))
		else $error("top room nonzero on a result that is not the last");

	// Assigned and reported rooms lie within the rooms in use.
	a_room_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((room <= sts.last_idx) && (top_room <= sts.last_idx)))
		else $error("result names a room outside the configured count");

	// A new result is loaded only when the output register can take it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("output register overwritten while stalled");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lowest-free resource scheduler. Jobs are driven
// mostly in ascending start order, with random gaps; the result channel is
// stalled at random, and each booking is compared with an in-bench room model.
// ----------------------------------------------------------------------------
module tb_top;
	import lfrs_pkg::*;

	// Run length and timing.
	localparam int JOB_TARGET    = 1720;
	// Quiet time after the last result: longer than one job plus the use-count
	// pass of a last job, so after it the block has gone idle.
	localparam int SETTLE_CYCLES = 48;
	// Limit for the global watchdog.
	localparam int CYCLE_LIMIT   = 1000000;
	localparam logic [IN_W-1:0] IN_MAX = '1;

	// One result transaction as it is seen on the output port.
	typedef struct packed {
		logic [ROOM_W-1:0]    room;
		logic [TIME_BITS-1:0] finish;
		logic [ROOM_W-1:0]    top;
		logic                 done;
	} booking_t;

	// The scoreboard keeps its own copy of the room state. Each accepted job
	// is booked here at once, and the booking it yields is queued until the
	// block returns the matching result.
	class booking_scoreboard;
		logic [TIME_BITS-1:0] free_at [ROOMS];
		logic [COUNT_W-1:0]   use_count [ROOMS];
		logic [CFG_W-1:0]     room_count;
		booking_t             expected_bookings [$];
		int                   mismatches;

		function new();
			foreach (free_at[i]) begin
				free_at[i]   = '0;
				use_count[i] = '0;
			end
			room_count = ROOM_COUNT_RST;
			mismatches = 0;
		endfunction

		function void set_room_count(logic [CFG_W-1:0] value);
			room_count = value;
		endfunction

		function void book_job(logic [IN_W-1:0] job_start, logic [IN_W-1:0] job_end,
				logic is_last);
			int                   n;
			int                   pick;
			int                   early;
			int                   best;
			bit                   found;
			logic [TIME_BITS-1:0] s_w;
			logic [TIME_BITS-1:0] e_w;
			logic [TIME_BITS-1:0] dur;
			logic [TIME_BITS-1:0] fin;
			booking_t             b;

			// A count of 0 behaves as 1 and anything above the room total as
			// the total.
			n = int'(room_count);
			if (n < 1) n = 1;
			if (n > ROOMS) n = ROOMS;
			s_w   = job_start;
			e_w   = job_end;
			pick  = 0;
			early = 0;
			found = 0;
			for (int i = 0; i < n; i++) begin
				if (!found && free_at[i] <= s_w) begin
					pick  = i;
					found = 1;
				end
				if (free_at[i] < free_at[early]) early = i;
			end
			if (found) begin
				fin = e_w;
			end else begin
				// Delayed jobs keep their length; an end not after the start
				// gives a zero length, and the finish saturates.
				dur  = (e_w > s_w) ? e_w - s_w : '0;
				pick = early;
				if (free_at[early] > TIME_MAX - dur) fin = TIME_MAX;
				else fin = free_at[early] + dur;
			end
			free_at[pick] = fin;
			if (use_count[pick] != COUNT_MAX) use_count[pick] = use_count[pick] + 1'b1;

			best = 0;
			if (is_last) begin
				for (int i = 1; i < n; i++) begin
					if (use_count[i] > use_count[best]) best = i;
				end
			end
			b.room   = pick[ROOM_W-1:0];
			b.finish = fin;
			b.top    = best[ROOM_W-1:0];
			b.done   = is_last;
			expected_bookings = {expected_bookings, b};
		endfunction

		function void check_booking(booking_t got);
			booking_t want;

			if (expected_bookings.size() == 0) begin
				$display("%0t: result with nothing expected: room %0d finish %0h",
					$time, got.room, got.finish);
				mismatches++;
				return;
			end
			want = expected_bookings.pop_front();
			if (got.room !== want.room) begin
				$display("%0t: room expected %0d actual %0d", $time, want.room, got.room);
				mismatches++;
			end
			if (got.finish !== want.finish) begin
				$display("%0t: finish_time expected %0h actual %0h",
					$time, want.finish, got.finish);
				mismatches++;
			end
			if (got.top !== want.top) begin
				$display("%0t: top_room expected %0d actual %0d", $time, want.top, got.top);
				mismatches++;
			end
			if (got.done !== want.done) begin
				$display("%0t: done_res expected %0b actual %0b", $time, want.done, got.done);
				mismatches++;
			end
		endfunction
	endclass

	// Every input starts at a known value.
	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [IN_W-1:0]      start_time = '0;
	logic [IN_W-1:0]      end_time   = '0;
	logic                 last       = 1'b0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic [ROOM_W-1:0]    room;
	logic [TIME_BITS-1:0] finish_time;
	logic [ROOM_W-1:0]    top_room;
	logic                 done_res;

	booking_scoreboard board = new();
	booking_t          seen_booking;

	// Stimulus state: quiet flags switch off idling on one side for a stretch,
	// and the cursor is the running start time of well-formed job sets.
	bit in_quiet    = 1'b0;
	bit out_quiet   = 1'b0;
	int clock_cursor;
	int jobs_sent   = 0;
	int set_count   = 0;
	int stall_left  = 0;
	int stall_roll;
	int cycle_count = 0;

	lowest_free_resource_scheduler dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_time (start_time),
		.end_time   (end_time),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.room       (room),
		.finish_time(finish_time),
		.top_room   (top_room),
		.done_res   (done_res)
	);

	always #2 clk = ~clk;

	// Global watchdog. A hung handshake or a lost result ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The result side stalls at random: mostly single cycles, now and then a
	// long hold, and no new stall starts while out_quiet is set.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (out_quiet) begin
			out_stall <= 1'b0;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 70) begin
				out_stall <= 1'b0;
			end else if (stall_roll < 96) begin
				out_stall <= 1'b1;
			end else begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(8, 40);
			end
		end
	end

	// Result monitor. Signals are read in the active region of the edge, so
	// they hold their values from before the edge, which is what the block
	// itself sees when the transaction completes.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_booking.room   = room;
			seen_booking.finish = finish_time;
			seen_booking.top    = top_room;
			seen_booking.done   = done_res;
			board.check_booking(seen_booking);
		end
	end

	// Idle cycles ahead of the next job: mostly none, sometimes a few, rarely
	// a long pause.
	function automatic int pick_gap();
		int roll;

		if (in_quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drives one job and waits for its transaction. in_valid only drops when
	// a gap follows, so it is never lowered and raised in the same step.
	task automatic send_job(logic [IN_W-1:0] job_start, logic [IN_W-1:0] job_end,
			logic is_last);
		int gap;

		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		start_time <= job_start;
		end_time   <= job_end;
		last       <= is_last;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.book_job(job_start, job_end, is_last);
		jobs_sent++;
	endtask

	// Waits until every booking has come back, then lets the block settle so
	// that the room count can be changed safely.
	task automatic drain_bookings();
		in_valid <= 1'b0;
		while (board.expected_bookings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_room_count(logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		board.set_room_count(value);
	endtask

	// One set of jobs; a well-formed set is closed by a last job and walks the
	// start cursor upward with ends not before starts; a broken set uses
	// arbitrary starts, ends and last marks.
	task automatic run_job_set(int set_len, bit broken);
		logic [IN_W-1:0] job_start;
		logic [IN_W-1:0] job_end;
		int              span;
		int              end_sum;

		for (int k = 0; k < set_len; k++) begin
			if (broken) begin
				job_start = IN_W'($urandom);
				job_end   = IN_W'($urandom);
				if (k == set_len - 1) send_job(job_start, job_end, 1'($urandom_range(0, 1)));
				else send_job(job_start, job_end, ($urandom_range(0, 7) == 0));
			end else begin
				job_start = clock_cursor[IN_W-1:0];
				// Short jobs keep rooms turning over; a few long ones force
				// delays onto the earliest room.
				if ($urandom_range(0, 99) < 85) span = $urandom_range(1, 300);
				else span = $urandom_range(1, int'(IN_MAX));
				end_sum = clock_cursor + span;
				if (end_sum > int'(IN_MAX)) end_sum = int'(IN_MAX);
				job_end = end_sum[IN_W-1:0];
				send_job(job_start, job_end, (k == set_len - 1));
				clock_cursor = clock_cursor + $urandom_range(0, 60);
				if (clock_cursor > int'(IN_MAX)) clock_cursor = int'(IN_MAX);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset room count: field extremes, an end equal to the start on a
		// free room, and an end before the start on the last job.
		send_job('0, IN_MAX, 1'b0);
		send_job('0, IN_W'(2), 1'b0);
		send_job(IN_W'(3), IN_W'(3), 1'b0);
		send_job(IN_MAX, IN_MAX, 1'b0);
		send_job(IN_MAX, '0, 1'b1);
		drain_bookings();

		// A count of zero acts as one room: every job lands on room 0, including
		// one out of start order and two with an end not after the start.
		write_room_count('0);
		send_job(IN_W'(10), IN_W'(20), 1'b0);
		send_job(IN_W'(5), IN_W'(3), 1'b0);
		send_job(IN_W'('h55555), IN_W'('hAAAAA), 1'b0);
		send_job(IN_W'('hAAAAA), IN_W'('h55555), 1'b1);
		drain_bookings();

		// A count above the room total acts as the total. Rooms 1 and up
		// still hold their old state from the first set.
		write_room_count(CFG_W'(31));
		send_job(IN_W'('h100), IN_W'('h200), 1'b0);
		send_job(IN_W'('h100), IN_W'('h180), 1'b0);
		send_job(IN_W'('h150), IN_W'('h160), 1'b0);
		send_job(IN_W'('h150), IN_W'('h151), 1'b1);
		drain_bookings();

		// A single room while the others keep their state.
		write_room_count(CFG_W'(1));
		send_job('0, IN_W'(1), 1'b0);
		send_job(IN_W'('h10), IN_W'('h20), 1'b0);
		send_job(IN_W'('h10), IN_W'('h30), 1'b1);
		drain_bookings();

		write_room_count(CFG_W'(16));
		send_job('0, '0, 1'b1);
		send_job(IN_W'('h400), IN_W'('h401), 1'b1);

		// Random part. The room count changes every ten sets, with the
		// extremes favored.
		clock_cursor = $urandom_range(0, 'h3FF);
		while (jobs_sent < JOB_TARGET) begin
			if (set_count % 10 == 9) begin
				drain_bookings();
				case ($urandom_range(0, 5))
					0: write_room_count('0);
					1: write_room_count(CFG_W'(1));
					2: write_room_count(CFG_W'(16));
					3: write_room_count(CFG_W'(31));
					default: write_room_count(CFG_W'($urandom_range(0, 31)));
				endcase
			end
			in_quiet  = ($urandom_range(0, 4) == 0);
			out_quiet = ($urandom_range(0, 4) == 0);
			// Occasional jumps carry the start cursor across the whole range.
			if ($urandom_range(0, 9) == 0) begin
				clock_cursor = clock_cursor + $urandom_range(0, 'h20000);
				if (clock_cursor > int'(IN_MAX)) clock_cursor = int'(IN_MAX);
			end
			run_job_set($urandom_range(1, 14), ($urandom_range(0, 4) == 0));
			set_count++;
		end
		drain_bookings();

		if (board.mismatches == 0 && board.expected_bookings.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
